@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion helpers
// Assertions sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/acb_pkg.sv @@
// ----------------------------------------------------------------------------
// acb_pkg
// Types and fixed constants of the ambient-cancelled light barrier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acb_pkg;

	// measurement phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DARK  = 2'd1,
		PH_LIGHT = 2'd2
	} phase_t;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_PERIOD    = 2'd1;
	localparam cfg_idx_t CFG_ON_DELAY  = 2'd2;
	localparam cfg_idx_t CFG_OFF_DELAY = 2'd3;

	// register reset values
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd256;
	localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd200;
	localparam logic [CFG_W-1:0] DELAY_RST     = 16'd0;

	// millisecond time base
	localparam int TIME_W = 32;

endpackage

@@ rtl/core/acb_div_const.sv @@
// ----------------------------------------------------------------------------
// acb_div_const
// Unsigned division by a fixed divisor through an exact reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acb_div_const #(
	parameter int IN_W    = 15,
	parameter int DIVISOR = 5,
	parameter int OUT_W   = 12
) (
	input  logic [IN_W-1:0]  num,
	output logic [OUT_W-1:0] quot
);

	// shift wide enough that the rounded-up reciprocal is exact for every input
	localparam int LOG_D = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
	localparam int SHIFT = IN_W + LOG_D;
	localparam int RW    = IN_W + 1;
	localparam int PW    = IN_W + RW;
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic [PW-1:0] prod;

	// quotient is the product shifted down
	assign prod = PW'(num) * PW'(RECIP);
	assign quot = prod[SHIFT +: OUT_W];

endmodule

@@ rtl/core/ambient_cancelled_light_barrier.sv @@
// ----------------------------------------------------------------------------
// ambient_cancelled_light_barrier: one state update per item feeds the result register.
// Throughput 1 item per cycle, held while a result waits untaken in the result register.
// Async active-low reset: idle phase, counters zero, config at threshold 256, period 200.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ambient_cancelled_light_barrier #(
	parameter int ADC_BITS          = 12,
	parameter int SAMPLES_PER_PHASE = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  acb_pkg::cfg_idx_t             cfg_index,
	input  logic [acb_pkg::CFG_W-1:0]     cfg_data,
	// input items
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// sample
	input  logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
	// action (0 tick, 1 sample)
	input  logic                          s_axis_tuser,
	// result items
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// emitter_on, sample_request, raw_state, detected, publish_event,
	// measure_done, dark_average, light_average
	output logic [((6+2*ADC_BITS+7)/8)*8-1:0] m_axis_tdata
);

	import acb_pkg::*;

	localparam int LOG_N  = (SAMPLES_PER_PHASE > 1) ? $clog2(SAMPLES_PER_PHASE) : 0;
	localparam int SUM_W  = ADC_BITS + LOG_N;
	localparam int CNT_W  = (SAMPLES_PER_PHASE > 1) ? $clog2(SAMPLES_PER_PHASE) : 1;
	localparam int CMP_W  = ADC_BITS + CFG_W;
	localparam int OUT_DW = ((6 + 2*ADC_BITS + 7) / 8) * 8;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_PHASE - 1);

	// configuration registers
	logic [CFG_W-1:0] thr_q, period_q, on_dly_q, off_dly_q;

	// measurement state
	phase_t              phase_q, phase_n;
	logic [TIME_W-1:0]   time_q, time_n;
	logic [TIME_W-1:0]   last_start_q, last_start_n;
	logic [TIME_W-1:0]   last_change_q, last_change_n;
	logic [CFG_W-1:0]    pend_q, pend_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;
	logic [SUM_W-1:0]    acc_q, acc_n;
	logic [ADC_BITS-1:0] dark_avg_q, dark_avg_n;
	logic                raw_q, raw_n;
	logic                pub_q, pub_n;

	// per-item signals
	logic                accept;
	logic                is_sample;
	logic [ADC_BITS-1:0] sample;
	logic [SUM_W-1:0]    acc_sum;
	logic [ADC_BITS-1:0] avg;
	logic [TIME_W-1:0]   tick_time;
	logic [TIME_W-1:0]   since_start;
	logic [TIME_W-1:0]   since_change;
	logic [CMP_W-1:0]    light_scaled;
	logic [CMP_W-1:0]    thr_prod;
	logic                new_raw;
	logic                done, event_n;

	// result register
	logic                m_valid_q;
	logic                emit_r, req_r, raw_r, det_r, ev_r, done_r;
	logic [ADC_BITS-1:0] dark_r, light_r;
	logic                emit_s1, req_s1, raw_s1, det_s1, ev_s1, done_s1;
	logic [ADC_BITS-1:0] dark_s1, light_s1;

	// handshake: a result slot frees when it is taken
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_sample     = s_axis_tuser;
	assign sample        = s_axis_tdata[ADC_BITS-1:0];

	// accumulate and average the current phase
	assign acc_sum = acc_q + SUM_W'(sample);

	acb_div_const #(
		.IN_W    (SUM_W),
		.DIVISOR (SAMPLES_PER_PHASE),
		.OUT_W   (ADC_BITS)
	) u_div (
		.num  (acc_sum),
		.quot (avg)
	);

	// ratio test; a zero dark average reduces to light nonzero
	assign light_scaled = CMP_W'({avg, 8'd0});
	assign thr_prod     = CMP_W'(thr_q) * CMP_W'(dark_avg_q);
	assign new_raw      = light_scaled > thr_prod;

	// elapsed times, modulo the time base
	assign tick_time    = time_q + TIME_W'(1);
	assign since_start  = tick_time - last_start_q;
	assign since_change = time_q - last_change_q;

	// next state
	always_comb begin
		phase_n       = phase_q;
		time_n        = time_q;
		last_start_n  = last_start_q;
		last_change_n = last_change_q;
		pend_n        = pend_q;
		cnt_n         = cnt_q;
		acc_n         = acc_q;
		dark_avg_n    = dark_avg_q;
		raw_n         = raw_q;
		pub_n         = pub_q;
		done          = 1'b0;
		event_n       = 1'b0;
		if (!is_sample) begin
			time_n = tick_time;
			if ((phase_q != PH_DARK) && (phase_q != PH_LIGHT)) begin
				phase_n = PH_IDLE;
				if (since_start > TIME_W'(period_q)) begin
					last_start_n = tick_time;
					phase_n      = PH_DARK;
					cnt_n        = '0;
					acc_n        = '0;
				end
			end
		end else begin
			case (phase_q)
				PH_DARK: begin
					if (cnt_q == CNT_LAST) begin
						cnt_n      = '0;
						acc_n      = '0;
						dark_avg_n = avg;
						phase_n    = PH_LIGHT;
					end else begin
						cnt_n = cnt_q + CNT_W'(1);
						acc_n = acc_sum;
					end
				end
				PH_LIGHT: begin
					if (cnt_q == CNT_LAST) begin
						cnt_n   = '0;
						acc_n   = '0;
						phase_n = PH_IDLE;
						done    = 1'b1;
						if (new_raw != raw_q) begin
							// a fresh change has zero elapsed time, never published now
							raw_n         = new_raw;
							last_change_n = time_q;
							pend_n        = new_raw ? on_dly_q : off_dly_q;
						end else if ((since_change > TIME_W'(pend_q)) && (raw_q != pub_q)) begin
							pub_n   = raw_q;
							event_n = 1'b1;
						end
					end else begin
						cnt_n = cnt_q + CNT_W'(1);
						acc_n = acc_sum;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	// result fields
	always_comb begin
		emit_r  = (phase_n == PH_LIGHT);
		req_r   = (phase_n != PH_IDLE);
		raw_r   = raw_n;
		det_r   = pub_n;
		ev_r    = event_n;
		done_r  = done;
		dark_r  = done ? dark_avg_q : '0;
		light_r = done ? avg : '0;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RST;
			period_q  <= PERIOD_RST;
			on_dly_q  <= DELAY_RST;
			off_dly_q <= DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q     <= cfg_data;
				CFG_PERIOD:    period_q  <= cfg_data;
				CFG_ON_DELAY:  on_dly_q  <= cfg_data;
				CFG_OFF_DELAY: off_dly_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// measurement state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			time_q        <= '0;
			last_start_q  <= '0;
			last_change_q <= '0;
			pend_q        <= '0;
			cnt_q         <= '0;
			acc_q         <= '0;
			raw_q         <= 1'b0;
			pub_q         <= 1'b0;
		end else if (accept) begin
			phase_q       <= phase_n;
			time_q        <= time_n;
			last_start_q  <= last_start_n;
			last_change_q <= last_change_n;
			pend_q        <= pend_n;
			cnt_q         <= cnt_n;
			acc_q         <= acc_n;
			raw_q         <= raw_n;
			pub_q         <= pub_n;
		end
	end

	// dark average holds from end of dark phase to end of light phase
	always_ff @(posedge clk) begin
		if (accept) begin
			dark_avg_q <= dark_avg_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1  <= emit_r;
			req_s1   <= req_r;
			raw_s1   <= raw_r;
			det_s1   <= det_r;
			ev_s1    <= ev_r;
			done_s1  <= done_r;
			dark_s1  <= dark_r;
			light_s1 <= light_r;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DW'({light_s1, dark_s1, done_s1, ev_s1, det_s1, raw_s1,
		req_s1, emit_s1});

	// checks
	`ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_LAST, "sample count beyond phase length")
	`ASSERT_IMPL(a_done_idle, m_valid_q && done_s1, !emit_s1 && !req_s1,
		"finished measurement not reported idle")
	`ASSERT_IMPL(a_event_follows_raw, m_valid_q && ev_s1, det_s1 == raw_s1,
		"published state differs from raw state on event")
	`ASSERT_NEXT(a_idle_no_light, accept && (phase_q == PH_IDLE), phase_q != PH_LIGHT,
		"light phase entered straight from idle")

endmodule
